FILE: sv/e2g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2g_pkg
// Shared types, constants and the CORDIC arctangent table for the ECEF to
// geodetic converter.
// ----------------------------------------------------------------------------
package e2g_pkg;

  typedef logic signed [34:0] pos_t;   // ECEF coordinate, mm
  typedef logic signed [31:0] ang_t;   // angle, 2^-31 semicircle
  typedef logic signed [34:0] hgt_t;   // height, mm

  // WGS-84 semi-major axis in mm, Q8
  localparam logic [40:0] A_Q8     = 41'd1632803072000;
  // first eccentricity squared, Q30
  localparam logic [31:0] E2_Q30   = 32'd7188036;
  // inverse CORDIC gain, Q30
  localparam logic [31:0] KINV_Q30 = 32'd652032874;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned DIV_STEPS    = 74;  // numerator bits of the divider
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned MAX_PASSES   = 11;

  // atan(2^-i) in 2^-31 semicircle
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/e2g_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2g_in_if
// Position channel: valid/ready with one ECEF position per transfer.
// ----------------------------------------------------------------------------
interface e2g_in_if import e2g_pkg::*; ();
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: sv/e2g_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2g_out_if
// Result channel: valid/ready with longitude, latitude and height.
// ----------------------------------------------------------------------------
interface e2g_out_if import e2g_pkg::*; ();
  logic valid;
  logic ready;
  ang_t longitude;
  ang_t latitude;
  hgt_t height;

  modport source (output valid, output longitude, output latitude, output height,
                  input ready);
  modport sink   (input valid, input longitude, input latitude, input height,
                  output ready);
endinterface

FILE: sv/ecef_to_geodetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecef_to_geodetic_unit
// WGS-84 ECEF (mm) to longitude / geodetic latitude / ellipsoidal height.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one ECEF position per transfer (pos_x, pos_y, pos_z in mm).
//   out_o : longitude and latitude in 2^-31 semicircle, height in mm.
//   in_i.ready is high only while the sequencer is idle; one position is
//   worked on at a time.
// Passes: each position takes 1 to 11 latitude passes, and the longitude
//   CORDIC is skipped when x and y are both zero. Each pass runs one
//   31-step CORDIC, two 74-step restoring divides, a 32-step integer
//   square root and five multiplies, all on one shared set of units.
// Output: the result sits in an output register; a new position can be taken
//   while it waits. If the receiver stalls and a second result is done, the
//   sequencer holds in its final state until the register frees up.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module ecef_to_geodetic_unit import e2g_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  e2g_in_if.sink        in_i,
  e2g_out_if.source     out_o
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_CPRE   = 20'h00002,
    S_CROT   = 20'h00004,
    S_CMAG   = 20'h00008,
    S_MLO    = 20'h00010,
    S_MHI    = 20'h00020,
    S_LON    = 20'h00040,
    S_DZ0    = 20'h00080,
    S_PASS   = 20'h00100,
    S_RDONE  = 20'h00200,
    S_DIV    = 20'h00400,
    S_SMDONE = 20'h00800,
    S_S2DONE = 20'h01000,
    S_WDONE  = 20'h02000,
    S_SQRT   = 20'h04000,
    S_NDIV   = 20'h08000,
    S_NDONE  = 20'h10000,
    S_NEDONE = 20'h20000,
    S_DMDONE = 20'h40000,
    S_FIN    = 20'h80000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic   phase_q, phase_d;          // 0: longitude CORDIC, 1: latitude CORDIC
  logic [6:0] cnt_q, cnt_d;
  logic [3:0] pass_q, pass_d;

  logic signed [42:0] zq_q, zq_d;
  logic signed [49:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [33:0] ang_q, ang_d, lat_q, lat_d;
  logic [31:0]        lon_q, lon_d;
  logic [47:0]        p_q, p_d, r_q, r_d, nq_q, nq_d;
  logic signed [43:0] dz_q, dz_d, zprev_q, zprev_d;
  logic signed [44:0] zz_q, zz_d;
  logic [30:0]        sm_q, sm_d;

  logic [47:0] mul_a_q, mul_a_d;
  logic [31:0] mul_b_q, mul_b_d;
  logic [55:0] mul_lo_q, mul_lo_d;
  logic [49:0] mul_res_q, mul_res_d;

  logic [73:0] div_n_q, div_n_d;
  logic [47:0] div_d_q, div_d_d, div_rem_q, div_rem_d, div_quo_q, div_quo_d;
  logic        div_ovf_q, div_ovf_d;

  logic [63:0] sq_n_q, sq_n_d, sq_res_q, sq_res_d;

  logic       out_valid_q, out_valid_d;
  ang_t       out_lon_q, out_lon_d, out_lat_q, out_lat_d;
  hgt_t       out_hgt_q, out_hgt_d;

  // shared datapath
  logic signed [49:0] cr_dx, cr_dy;
  logic signed [33:0] cr_atan;
  logic [23:0]        mul_x;
  logic [55:0]        mul_p;
  logic [79:0]        mul_sum;
  logic [48:0]        div_r2;
  logic               div_ge;
  logic [63:0]        sq_bit, sq_t;
  logic               sq_ge;
  logic signed [42:0] xs, ys, zs;
  logic signed [43:0] zq_ext, dm_s;
  logic [42:0]        zq_mag;
  logic signed [44:0] zz_sum, zz_neg;
  logic [30:0]        sm_next;
  logic signed [43:0] dz_new;
  logic signed [49:0] h_sum, h_shr;
  state_e             cmag_ret;

  assign cr_dx   = cy_q >>> cnt_q[4:0];
  assign cr_dy   = cx_q >>> cnt_q[4:0];
  assign cr_atan = $signed({4'b0000, atan_lut(cnt_q[4:0])});

  assign mul_x   = (state_q == S_MLO) ? mul_a_q[23:0] : mul_a_q[47:24];
  assign mul_p   = mul_x * mul_b_q;
  assign mul_sum = {mul_p, 24'd0} + {24'd0, mul_lo_q};

  assign div_r2  = {div_rem_q, div_n_q[73]};
  assign div_ge  = div_r2 >= {1'b0, div_d_q};

  assign sq_bit  = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
  assign sq_t    = sq_res_q + sq_bit;
  assign sq_ge   = sq_n_q >= sq_t;

  assign xs      = $signed({in_i.pos_x, 8'h00});
  assign ys      = $signed({in_i.pos_y, 8'h00});
  assign zs      = $signed({in_i.pos_z, 8'h00});
  assign zq_ext  = {zq_q[42], zq_q};
  assign zq_mag  = zq_q[42] ? 43'(-zq_ext) : 43'(zq_ext);
  assign zz_sum  = {dz_q[43], dz_q} + {{2{zq_q[42]}}, zq_q};
  assign zz_neg  = -zz_q;
  assign dm_s    = $signed({1'b0, mul_res_q[42:0]});
  assign dz_new  = zz_q[44] ? -dm_s : dm_s;
  assign cmag_ret = phase_q ? S_RDONE : S_LON;

  // sine magnitude, clamped to one; zero divisor gives zero
  always_comb begin
    if (r_q == '0) begin
      sm_next = '0;
    end else if (div_ovf_q || (div_quo_q > {17'd0, ONE_Q30})) begin
      sm_next = ONE_Q30;
    end else begin
      sm_next = div_quo_q[30:0];
    end
  end

  assign h_sum = $signed({2'b00, r_q}) - $signed({2'b00, nq_q}) + 50'sd128;
  assign h_shr = h_sum >>> 8;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    zq_d        = zq_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    ang_d       = ang_q;
    lat_d       = lat_q;
    lon_d       = lon_q;
    p_d         = p_q;
    r_d         = r_q;
    nq_d        = nq_q;
    dz_d        = dz_q;
    zprev_d     = zprev_q;
    zz_d        = zz_q;
    sm_d        = sm_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_lo_d    = mul_lo_q;
    mul_res_d   = mul_res_q;
    div_n_d     = div_n_q;
    div_d_d     = div_d_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_ovf_d   = div_ovf_q;
    sq_n_d      = sq_n_q;
    sq_res_d    = sq_res_q;
    out_lon_d   = out_lon_q;
    out_lat_d   = out_lat_q;
    out_hgt_d   = out_hgt_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cx_d    = {{7{xs[42]}}, xs};
          cy_d    = {{7{ys[42]}}, ys};
          zq_d    = zs;
          phase_d = 1'b0;
          state_d = S_CPRE;
        end
      end
      S_CPRE: begin
        cnt_d = '0;
        if (cx_q == '0 && cy_q == '0) begin
          // zero vector: angle and magnitude are zero
          ang_d   = '0;
          mul_a_d = '0;
          mul_b_d = KINV_Q30;
          ret_d   = cmag_ret;
          state_d = S_MLO;
        end else begin
          ang_d = '0;
          if (cx_q < 0) begin
            if (cy_q >= 0) begin
              cx_d  = cy_q;
              cy_d  = -cx_q;
              ang_d = 34'sh0_4000_0000;
            end else begin
              cx_d  = -cy_q;
              cy_d  = cx_q;
              ang_d = -34'sh0_4000_0000;
            end
          end
          state_d = S_CROT;
        end
      end
      S_CROT: begin
        if (!cy_q[49]) begin
          cx_d  = cx_q + cr_dx;
          cy_d  = cy_q - cr_dy;
          ang_d = ang_q + cr_atan;
        end else begin
          cx_d  = cx_q - cr_dx;
          cy_d  = cy_q + cr_dy;
          ang_d = ang_q - cr_atan;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(CORDIC_STEPS - 1)) begin
          state_d = S_CMAG;
        end
      end
      S_CMAG: begin
        mul_a_d = (cx_q > 0) ? cx_q[47:0] : '0;
        mul_b_d = KINV_Q30;
        ret_d   = cmag_ret;
        state_d = S_MLO;
      end
      S_MLO: begin
        mul_lo_d = mul_p;
        state_d  = S_MHI;
      end
      S_MHI: begin
        mul_res_d = mul_sum[79:30];
        state_d   = ret_q;
      end
      S_LON: begin
        lon_d   = ang_q[31:0];
        p_d     = mul_res_q[47:0];
        mul_a_d = {5'd0, zq_mag};
        mul_b_d = E2_Q30;
        ret_d   = S_DZ0;
        state_d = S_MLO;
      end
      S_DZ0: begin
        dz_d    = zq_q[42] ? -dm_s : dm_s;
        pass_d  = 4'd1;
        state_d = S_PASS;
      end
      S_PASS: begin
        zprev_d = dz_q;
        zz_d    = zz_sum;
        cx_d    = {2'b00, p_q};
        cy_d    = {{5{zz_sum[44]}}, zz_sum};
        phase_d = 1'b1;
        state_d = S_CPRE;
      end
      S_RDONE: begin
        lat_d     = ang_q;
        r_d       = mul_res_q[47:0];
        div_n_d   = {(zz_q[44] ? zz_neg[43:0] : zz_q[43:0]), 30'd0};
        div_d_d   = mul_res_q[47:0];
        div_rem_d = '0;
        div_quo_d = '0;
        div_ovf_d = 1'b0;
        cnt_d     = '0;
        ret_d     = S_SMDONE;
        state_d   = S_DIV;
      end
      S_DIV: begin
        div_n_d   = {div_n_q[72:0], 1'b0};
        div_rem_d = div_ge ? 48'(div_r2 - {1'b0, div_d_q}) : div_r2[47:0];
        div_quo_d = {div_quo_q[46:0], div_ge};
        div_ovf_d = div_ovf_q | div_quo_q[47];
        cnt_d     = cnt_q + 7'd1;
        if (cnt_q == 7'(DIV_STEPS - 1)) begin
          state_d = ret_q;
        end
      end
      S_SMDONE: begin
        sm_d    = sm_next;
        mul_a_d = {17'd0, sm_next};
        mul_b_d = {1'b0, sm_next};
        ret_d   = S_S2DONE;
        state_d = S_MLO;
      end
      S_S2DONE: begin
        mul_a_d = mul_res_q[47:0];
        mul_b_d = E2_Q30;
        ret_d   = S_WDONE;
        state_d = S_MLO;
      end
      S_WDONE: begin
        sq_n_d   = {1'b0, ONE_Q30 - mul_res_q[30:0], 32'd0};
        sq_res_d = '0;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sq_n_d   = sq_n_q - sq_t;
          sq_res_d = (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(SQRT_STEPS - 1)) begin
          state_d = S_NDIV;
        end
      end
      S_NDIV: begin
        div_n_d   = {2'b00, A_Q8, 31'd0};
        div_d_d   = {16'd0, sq_res_q[31:0]};
        div_rem_d = '0;
        div_quo_d = '0;
        div_ovf_d = 1'b0;
        cnt_d     = '0;
        ret_d     = S_NDONE;
        state_d   = S_DIV;
      end
      S_NDONE: begin
        nq_d    = div_quo_q;
        mul_a_d = div_quo_q;
        mul_b_d = E2_Q30;
        ret_d   = S_NEDONE;
        state_d = S_MLO;
      end
      S_NEDONE: begin
        mul_a_d = mul_res_q[47:0];
        mul_b_d = {1'b0, sm_q};
        ret_d   = S_DMDONE;
        state_d = S_MLO;
      end
      S_DMDONE: begin
        dz_d = dz_new;
        // converged when a pass leaves the correction unchanged, or MAX_PASSES reached
        if (dz_new == zprev_q || pass_q == 4'(MAX_PASSES)) begin
          state_d = S_FIN;
        end else begin
          pass_d  = pass_q + 4'd1;
          state_d = S_PASS;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_lon_d = lon_q;
          if (lat_q > 34'sh0_4000_0000) begin
            out_lat_d = 32'sh4000_0000;
          end else if (lat_q < -34'sh0_4000_0000) begin
            out_lat_d = -32'sh4000_0000;
          end else begin
            out_lat_d = lat_q[31:0];
          end
          if (h_shr > 50'sd10000000000) begin
            out_hgt_d = 35'sd10000000000;
          end else if (h_shr < -50'sd10000000000) begin
            out_hgt_d = -35'sd10000000000;
          end else begin
            out_hgt_d = h_shr[34:0];
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zq_q      <= zq_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    ang_q     <= ang_d;
    lat_q     <= lat_d;
    lon_q     <= lon_d;
    p_q       <= p_d;
    r_q       <= r_d;
    nq_q      <= nq_d;
    dz_q      <= dz_d;
    zprev_q   <= zprev_d;
    zz_q      <= zz_d;
    sm_q      <= sm_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_lo_q  <= mul_lo_d;
    mul_res_q <= mul_res_d;
    div_n_q   <= div_n_d;
    div_d_q   <= div_d_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_ovf_q <= div_ovf_d;
    sq_n_q    <= sq_n_d;
    sq_res_q  <= sq_res_d;
    out_lon_q <= out_lon_d;
    out_lat_q <= out_lat_d;
    out_hgt_q <= out_hgt_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.longitude = out_lon_q;
  assign out_o.latitude  = out_lat_q;
  assign out_o.height    = out_hgt_q;

  // assertions
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while busy");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < 7'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) |-> (pass_q >= 4'd1 && pass_q <= 4'(MAX_PASSES)))
    else $error("latitude pass count out of range");

  a_sine_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_S2DONE) |-> (sm_q <= ONE_Q30))
    else $error("sine magnitude above one");

endmodule
